FILE: hw/rtl/ybd_pkg.sv
// shared types, constants and helpers of the yolo box decoder
package ybd_pkg;

   typedef enum logic [1:0] {
      CMD_DECODE    = 2'd0,
      CMD_SIG_WRITE = 2'd1,
      CMD_EXP_WRITE = 2'd2,
      CMD_IGNORED   = 2'd3
   } cmd_type;

   localparam logic [1:0] CSR_GRID_HEIGHT = 2'd0;
   localparam logic [1:0] CSR_GRID_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_PRIOR_SCALE = 2'd2;

   localparam logic [7:0]  GRID_HEIGHT_RESET = 8'd13;
   localparam logic [7:0]  GRID_WIDTH_RESET  = 8'd13;
   localparam logic [15:0] PRIOR_SCALE_RESET = 16'd1;

   localparam int CSR_DATA_W = 16;
   localparam int DIV_NUM_W  = 40;
   localparam int DIV_DEN_W  = 16;
   localparam int COMP_SHIFT = 16;

   typedef struct packed {
      logic [31:0] sig_x;
      logic [31:0] sig_y;
      logic [31:0] exp_w;
      logic [31:0] exp_h;
      logic [7:0]  prior_x;
      logic [7:0]  prior_y;
      logic [7:0]  prior_w;
      logic [7:0]  prior_h;
   } dec_word_type;

   function automatic logic [31:0] sat32(input logic signed [41:0] v);
      logic [31:0] r;
      if (v > 42'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -42'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/ybd_if.sv
// request and response channel interfaces
interface ybd_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        command;
   logic signed [7:0] table_index;
   logic [31:0]       table_value;
   logic signed [7:0] loc_x;
   logic signed [7:0] loc_y;
   logic signed [7:0] loc_w;
   logic signed [7:0] loc_h;
   logic [7:0]        prior_x;
   logic [7:0]        prior_y;
   logic [7:0]        prior_w;
   logic [7:0]        prior_h;
   modport source (output valid, command, table_index, table_value, loc_x, loc_y, loc_w,
                   loc_h, prior_x, prior_y, prior_w, prior_h, input ready);
   modport sink (input valid, command, table_index, table_value, loc_x, loc_y, loc_w,
                 loc_h, prior_x, prior_y, prior_w, prior_h, output ready);
endinterface

interface ybd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_min;
   logic signed [31:0] x_max;
   logic signed [31:0] y_min;
   logic signed [31:0] y_max;
   modport source (output valid, x_min, x_max, y_min, y_max, input ready);
   modport sink (input valid, x_min, x_max, y_min, y_max, output ready);
endinterface

FILE: hw/rtl/ybd_front.sv
// front end: accepts words, updates tables, looks up decode operands
module ybd_front #(
   parameter int TABLE_DEPTH = 256,
   parameter int FIFO_DEPTH  = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   ybd_req_if.sink                            req,
   input  logic [$clog2(FIFO_DEPTH+1)-1:0]    fifo_count,
   output logic                               push,
   output ybd_pkg::dec_word_type              push_word
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH+1);

   logic [31:0] sig_mem [TABLE_DEPTH];
   logic [31:0] exp_mem [TABLE_DEPTH];
   logic        s1_valid_ff;
   logic [31:0] rd_sx_ff, rd_sy_ff, rd_ew_ff, rd_eh_ff;
   logic [7:0]  px_ff, py_ff, pw_ff, ph_ff;
   logic        accept, sig_we, exp_we, dec_go;

   assign req.ready = ({1'b0, fifo_count} + (CW+1)'(s1_valid_ff)) < (CW+1)'(FIFO_DEPTH);
   assign accept    = req.valid && req.ready;

   always_comb begin
      sig_we = 1'b0;
      exp_we = 1'b0;
      dec_go = 1'b0;
      unique case (ybd_pkg::cmd_type'(req.command))
         ybd_pkg::CMD_DECODE:    dec_go = accept;
         ybd_pkg::CMD_SIG_WRITE: sig_we = accept;
         ybd_pkg::CMD_EXP_WRITE: exp_we = accept;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (sig_we) begin
         sig_mem[req.table_index[AW-1:0]] <= req.table_value;
      end
      if (exp_we) begin
         exp_mem[req.table_index[AW-1:0]] <= req.table_value;
      end
      if (dec_go) begin
         rd_sx_ff <= sig_mem[req.loc_x[AW-1:0]];
         rd_sy_ff <= sig_mem[req.loc_y[AW-1:0]];
         rd_ew_ff <= exp_mem[req.loc_w[AW-1:0]];
         rd_eh_ff <= exp_mem[req.loc_h[AW-1:0]];
         px_ff    <= req.prior_x;
         py_ff    <= req.prior_y;
         pw_ff    <= req.prior_w;
         ph_ff    <= req.prior_h;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= dec_go;
      end
   end

   assign push              = s1_valid_ff;
   assign push_word.sig_x   = rd_sx_ff;
   assign push_word.sig_y   = rd_sy_ff;
   assign push_word.exp_w   = rd_ew_ff;
   assign push_word.exp_h   = rd_eh_ff;
   assign push_word.prior_x = px_ff;
   assign push_word.prior_y = py_ff;
   assign push_word.prior_w = pw_ff;
   assign push_word.prior_h = ph_ff;
endmodule

FILE: hw/rtl/ybd_fifo.sv
// short queue between front end and back end
module ybd_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  ybd_pkg::dec_word_type          push_word,
   input  logic                           pop,
   output ybd_pkg::dec_word_type          pop_word,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     count
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   ybd_pkg::dec_word_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_pop;

   assign do_pop   = pop && (count_ff != '0);
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_word = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CW'(push) - CW'(do_pop);
      end
   end
endmodule

FILE: hw/rtl/ybd_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
module ybd_div_pipe #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0] den_in,
   output logic [NUM_W-1:0] quo_out
);
   logic [NUM_W-1:0] nq_ff  [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_st
      logic [NUM_W-1:0] nq_prev;
      logic [DEN_W-1:0] rem_prev, den_prev;
      logic [DEN_W:0]   trial, diff;
      logic             ge;
      if (k == 0) begin : g_first
         assign nq_prev  = num_in;
         assign rem_prev = '0;
         assign den_prev = den_in;
      end else begin : g_next
         assign nq_prev  = nq_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
      end
      assign trial = {rem_prev, nq_prev[NUM_W-1]};
      assign diff  = trial - {1'b0, den_prev};
      assign ge    = trial >= {1'b0, den_prev};
      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff[k]  <= {nq_prev[NUM_W-2:0], ge};
            rem_ff[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            den_ff[k] <= den_prev;
         end
      end
   end

   assign quo_out = nq_ff[NUM_W-1];
endmodule

FILE: hw/rtl/ybd_back.sv
// back end: divisions, scaling, corner forming and output register
module ybd_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [1:0]                           csr_index,
   input  logic [ybd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  ybd_pkg::dec_word_type                word,
   input  logic                                 avail,
   output logic                                 pop,
   ybd_rsp_if.source                            rsp
);
   localparam int NW = ybd_pkg::DIV_NUM_W;
   localparam int DW = ybd_pkg::DIV_DEN_W;

   logic [7:0]  grid_h_ff, grid_w_ff;
   logic [15:0] scale_ff;
   logic [7:0]  gh_eff, gw_eff;
   logic [15:0] scl_eff;
   logic        en;

   logic [NW:0]   vld_ff;
   logic [31:0]   sx_line_ff [NW+1];
   logic [31:0]   sy_line_ff [NW+1];
   logic [NW-1:0] num_ax_ff, num_ay_ff, num_sw_ff, num_sh_ff;
   logic [NW-1:0] q_ax, q_ay, q_sw, q_sh, q_cx, q_cy;

   logic [48:0] prod_x, prod_y;
   logic        m_vld_ff, a_vld_ff, o_vld_ff;
   logic [32:0] cpx_ff, cpy_ff;
   logic [15:0] anx_ff, any_ff;
   logic [38:0] hw_m_ff, hh_m_ff, hw_a_ff, hh_a_ff;
   logic [33:0] cen_x_ff, cen_y_ff;
   logic signed [41:0] xd, xs, yd, ys;
   logic [31:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_h_ff <= ybd_pkg::GRID_HEIGHT_RESET;
         grid_w_ff <= ybd_pkg::GRID_WIDTH_RESET;
         scale_ff  <= ybd_pkg::PRIOR_SCALE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ybd_pkg::CSR_GRID_HEIGHT: grid_h_ff <= csr_wdata[7:0];
            ybd_pkg::CSR_GRID_WIDTH:  grid_w_ff <= csr_wdata[7:0];
            ybd_pkg::CSR_PRIOR_SCALE: scale_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // zero sizes act as one
   assign gh_eff  = (grid_h_ff == '0) ? 8'd1 : grid_h_ff;
   assign gw_eff  = (grid_w_ff == '0) ? 8'd1 : grid_w_ff;
   assign scl_eff = (scale_ff == '0) ? 16'd1 : scale_ff;

   assign en  = !o_vld_ff || rsp.ready;
   assign pop = en && avail;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         m_vld_ff <= 1'b0;
         a_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff   <= {vld_ff[NW-1:0], pop};
         m_vld_ff <= vld_ff[NW];
         a_vld_ff <= m_vld_ff;
         o_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx_line_ff[0] <= word.sig_x;
         sy_line_ff[0] <= word.sig_y;
         num_ax_ff     <= {24'd0, word.prior_x, 8'd0};
         num_ay_ff     <= {24'd0, word.prior_y, 8'd0};
         num_sw_ff     <= NW'(word.prior_w) * NW'(word.exp_w);
         num_sh_ff     <= NW'(word.prior_h) * NW'(word.exp_h);
         for (int k = 1; k <= NW; k++) begin
            sx_line_ff[k] <= sx_line_ff[k-1];
            sy_line_ff[k] <= sy_line_ff[k-1];
         end
      end
   end

   ybd_div_pipe #(.NUM_W(NW), .DEN_W(DW)) u_div_ax (
      .clock(clock), .en(en), .num_in(num_ax_ff), .den_in(scl_eff), .quo_out(q_ax));
   ybd_div_pipe #(.NUM_W(NW), .DEN_W(DW)) u_div_ay (
      .clock(clock), .en(en), .num_in(num_ay_ff), .den_in(scl_eff), .quo_out(q_ay));
   ybd_div_pipe #(.NUM_W(NW), .DEN_W(DW)) u_div_sw (
      .clock(clock), .en(en), .num_in(num_sw_ff), .den_in(scl_eff), .quo_out(q_sw));
   ybd_div_pipe #(.NUM_W(NW), .DEN_W(DW)) u_div_sh (
      .clock(clock), .en(en), .num_in(num_sh_ff), .den_in(scl_eff), .quo_out(q_sh));
   ybd_div_pipe #(.NUM_W(NW), .DEN_W(DW)) u_div_cx (
      .clock(clock), .en(en), .num_in(NW'(1) << ybd_pkg::COMP_SHIFT),
      .den_in({8'd0, gw_eff}), .quo_out(q_cx));
   ybd_div_pipe #(.NUM_W(NW), .DEN_W(DW)) u_div_cy (
      .clock(clock), .en(en), .num_in(NW'(1) << ybd_pkg::COMP_SHIFT),
      .den_in({8'd0, gh_eff}), .quo_out(q_cy));

   assign prod_x = 49'(sx_line_ff[NW]) * 49'(q_cx[16:0]);
   assign prod_y = 49'(sy_line_ff[NW]) * 49'(q_cy[16:0]);

   always_ff @(posedge clock) begin
      if (en) begin
         cpx_ff   <= prod_x[48:16];
         cpy_ff   <= prod_y[48:16];
         anx_ff   <= q_ax[15:0];
         any_ff   <= q_ay[15:0];
         hw_m_ff  <= q_sw[39:1];
         hh_m_ff  <= q_sh[39:1];
         cen_x_ff <= {1'b0, cpx_ff} + {18'd0, anx_ff};
         cen_y_ff <= {1'b0, cpy_ff} + {18'd0, any_ff};
         hw_a_ff  <= hw_m_ff;
         hh_a_ff  <= hh_m_ff;
         x_min_ff <= ybd_pkg::sat32(xd);
         x_max_ff <= ybd_pkg::sat32(xs);
         y_min_ff <= ybd_pkg::sat32(yd);
         y_max_ff <= ybd_pkg::sat32(ys);
      end
   end

   assign xd = $signed({8'd0, cen_x_ff}) - $signed({3'd0, hw_a_ff});
   assign xs = $signed({8'd0, cen_x_ff}) + $signed({3'd0, hw_a_ff});
   assign yd = $signed({8'd0, cen_y_ff}) - $signed({3'd0, hh_a_ff});
   assign ys = $signed({8'd0, cen_y_ff}) + $signed({3'd0, hh_a_ff});

   assign rsp.valid = o_vld_ff;
   assign rsp.x_min = $signed(x_min_ff);
   assign rsp.x_max = $signed(x_max_ff);
   assign rsp.y_min = $signed(y_min_ff);
   assign rsp.y_max = $signed(y_max_ff);
endmodule

FILE: hw/rtl/yolo_box_decode_unit.sv
// yolo box decoder top level
// Takes one word per cycle. Table writes finish in the cycle they are taken; a decode
// word reads both tables, waits in a four-entry queue and then runs a 44-stage back end
// whose length is set by the 40 quotient-bit stages of the divider lanes.
// A stalled response port holds the back end; the queue lets the front keep taking
// words until it fills.
module yolo_box_decode_unit #(
   parameter int TABLE_DEPTH = 256,
   parameter int FIFO_DEPTH  = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   ybd_req_if.sink                        req_ch,
   ybd_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_index,
   input  logic [ybd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   localparam int CW = $clog2(FIFO_DEPTH+1);

   logic                  push, pop, empty;
   logic [CW-1:0]         count;
   ybd_pkg::dec_word_type push_word, pop_word;

   ybd_front #(.TABLE_DEPTH(TABLE_DEPTH), .FIFO_DEPTH(FIFO_DEPTH)) u_front (
      .clock(clock), .reset(reset), .req(req_ch), .fifo_count(count),
      .push(push), .push_word(push_word));

   ybd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_word(push_word), .pop(pop),
      .pop_word(pop_word), .empty(empty), .count(count));

   ybd_back u_back (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .word(pop_word), .avail(!empty), .pop(pop), .rsp(rsp_ch));
endmodule

FILE: hw/rtl/ybd_checker.sv
// port-level checks of the yolo box decoder
module ybd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] x_min,
   input logic [31:0] x_max,
   input logic [31:0] y_min,
   input logic [31:0] y_max
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(x_min) && $stable(y_max))
      else $error("response dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   a_x_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(x_min) <= $signed(x_max))
      else $error("x corners out of order");

   a_y_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(y_min) <= $signed(y_max))
      else $error("y corners out of order");
endmodule

bind yolo_box_decode_unit ybd_checker u_ybd_checker (
   .clock(clock), .reset(reset), .req_ready(req_ch.ready), .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready), .x_min(rsp_ch.x_min), .x_max(rsp_ch.x_max),
   .y_min(rsp_ch.y_min), .y_max(rsp_ch.y_max));

FILE: bench/tb.sv
// self-checking testbench of the yolo box decoder: random and directed words, scoreboard
module tb;

   typedef struct {
      logic [1:0]  command;
      logic [7:0]  table_index;
      logic [31:0] table_value;
      logic [7:0]  loc_x, loc_y, loc_w, loc_h;
      logic [7:0]  prior_x, prior_y, prior_w, prior_h;
   } req_word_type;

   typedef struct {
      logic [31:0] x_min, x_max, y_min, y_max;
   } box_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = ybd_pkg::CSR_GRID_HEIGHT;
   logic [ybd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   ybd_req_if req_ch ();
   ybd_rsp_if rsp_ch ();

   yolo_box_decode_unit i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   req_word_type pending_words[$];
   box_type expected_boxes[$];
   logic [31:0] sig_mem[256];
   logic [31:0] exp_mem[256];
   bit sig_written[256];
   bit exp_written[256];
   logic [7:0] grid_h_reg, grid_w_reg;
   logic [15:0] scale_reg;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   longint cycles = 0;

   function automatic logic [63:0] center_of(logic [31:0] sig, logic [7:0] grid,
                                             logic [7:0] prior, logic [15:0] scl);
      logic [63:0] g, comp, s;
      g = (grid == 0) ? 64'd1 : {56'd0, grid};
      s = (scl == 0) ? 64'd1 : {48'd0, scl};
      comp = 64'd65536 / g;
      return ((64'(sig) * comp) >> 16) + (64'(prior) * 64'd256) / s;
   endfunction

   function automatic logic [63:0] half_of(logic [31:0] ex, logic [7:0] prior,
                                           logic [15:0] scl);
      logic [63:0] s;
      s = (scl == 0) ? 64'd1 : {48'd0, scl};
      return ((64'(prior) * 64'(ex)) / s) >> 1;
   endfunction

   function automatic logic [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   task automatic predict_box(req_word_type w);
      logic signed [63:0] x, y, hw, hh;
      box_type b;
      case (w.command)
         ybd_pkg::CMD_SIG_WRITE: sig_mem[w.table_index] = w.table_value;
         ybd_pkg::CMD_EXP_WRITE: exp_mem[w.table_index] = w.table_value;
         ybd_pkg::CMD_DECODE: begin
            x = center_of(sig_mem[w.loc_x], grid_w_reg, w.prior_x, scale_reg);
            y = center_of(sig_mem[w.loc_y], grid_h_reg, w.prior_y, scale_reg);
            hw = half_of(exp_mem[w.loc_w], w.prior_w, scale_reg);
            hh = half_of(exp_mem[w.loc_h], w.prior_h, scale_reg);
            b.x_min = clamp32(x - hw);
            b.x_max = clamp32(x + hw);
            b.y_min = clamp32(y - hh);
            b.y_max = clamp32(y + hh);
            expected_boxes.push_back(b);
         end
         default: ;
      endcase
   endtask

   function automatic req_word_type table_word(logic [1:0] cmd, logic [7:0] idx,
                                               logic [31:0] v);
      req_word_type w;
      w = '{default: '0};
      w.command = cmd;
      w.table_index = idx;
      w.table_value = v;
      if (cmd == ybd_pkg::CMD_SIG_WRITE) sig_written[idx] = 1;
      if (cmd == ybd_pkg::CMD_EXP_WRITE) exp_written[idx] = 1;
      return w;
   endfunction

   function automatic logic [7:0] pick_index(bit sig);
      logic [7:0] i;
      do i = $urandom_range(255, 0); while (sig ? !sig_written[i] : !exp_written[i]);
      return i;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      int r;
      w.table_index = $urandom_range(255, 0);
      w.table_value = $urandom();
      r = $urandom_range(99, 0);
      if (r < 12) w.command = ybd_pkg::CMD_SIG_WRITE;
      else if (r < 24) w.command = ybd_pkg::CMD_EXP_WRITE;
      else if (r < 28) w.command = ybd_pkg::CMD_IGNORED;
      else w.command = ybd_pkg::CMD_DECODE;
      if ($urandom_range(3, 0) == 0) w.table_value = $urandom_range(1, 0) ? 32'hffff_ffff : 0;
      if (w.command == ybd_pkg::CMD_SIG_WRITE) sig_written[w.table_index] = 1;
      if (w.command == ybd_pkg::CMD_EXP_WRITE) exp_written[w.table_index] = 1;
      w.loc_x = pick_index(1);
      w.loc_y = pick_index(1);
      w.loc_w = pick_index(0);
      w.loc_h = pick_index(0);
      w.prior_x = $urandom_range(255, 0);
      w.prior_y = $urandom_range(255, 0);
      w.prior_w = $urandom_range(255, 0);
      w.prior_h = $urandom_range(255, 0);
      return w;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_words.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_word_type w;
            w = pending_words.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.command <= w.command;
            req_ch.table_index <= w.table_index;
            req_ch.table_value <= w.table_value;
            req_ch.loc_x <= w.loc_x;
            req_ch.loc_y <= w.loc_y;
            req_ch.loc_w <= w.loc_w;
            req_ch.loc_h <= w.loc_h;
            req_ch.prior_x <= w.prior_x;
            req_ch.prior_y <= w.prior_y;
            req_ch.prior_w <= w.prior_w;
            req_ch.prior_h <= w.prior_h;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.command = ybd_pkg::CMD_DECODE;
      req_ch.table_index = '0;
      req_ch.table_value = '0;
      {req_ch.loc_x, req_ch.loc_y, req_ch.loc_w, req_ch.loc_h} = '0;
      {req_ch.prior_x, req_ch.prior_y, req_ch.prior_w, req_ch.prior_h} = '0;
      rsp_ch.ready = 1'b0;
   end

   // prediction on accepted words
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         req_word_type w;
         w.command = req_ch.command;
         w.table_index = req_ch.table_index;
         w.table_value = req_ch.table_value;
         w.loc_x = req_ch.loc_x;
         w.loc_y = req_ch.loc_y;
         w.loc_w = req_ch.loc_w;
         w.loc_h = req_ch.loc_h;
         w.prior_x = req_ch.prior_x;
         w.prior_y = req_ch.prior_y;
         w.prior_w = req_ch.prior_w;
         w.prior_h = req_ch.prior_h;
         predict_box(w);
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_ch.ready <= !reset && ($urandom_range(99, 0) >= recv_stall_pct);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_boxes.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected box %h %h %h %h", rsp_ch.x_min,
                                          rsp_ch.x_max, rsp_ch.y_min, rsp_ch.y_max);
         end else begin
            box_type e;
            e = expected_boxes.pop_front();
            if (e.x_min !== rsp_ch.x_min || e.x_max !== rsp_ch.x_max ||
                e.y_min !== rsp_ch.y_min || e.y_max !== rsp_ch.y_max) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("box mismatch exp %h %h %h %h got %h %h %h %h",
                           e.x_min, e.x_max, e.y_min, e.y_max, rsp_ch.x_min,
                           rsp_ch.x_max, rsp_ch.y_min, rsp_ch.y_max);
            end
         end
      end
      if (cycles > 2000000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic drain();
      while (pending_words.size() != 0 || req_ch.valid || expected_boxes.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         ybd_pkg::CSR_GRID_HEIGHT: grid_h_reg = v[7:0];
         ybd_pkg::CSR_GRID_WIDTH: grid_w_reg = v[7:0];
         default: scale_reg = v;
      endcase
   endtask

   initial begin
      logic [15:0] scales[5];
      logic [7:0] grids[5];
      scales = '{16'd1, 16'd65535, 16'd3, 16'd255, 16'd17};
      grids = '{8'd1, 8'd255, 8'd13, 8'd7, 8'd52};
      grid_h_reg = ybd_pkg::GRID_HEIGHT_RESET;
      grid_w_reg = ybd_pkg::GRID_WIDTH_RESET;
      scale_reg = ybd_pkg::PRIOR_SCALE_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: table extremes, all commands, saturation
      pending_words.push_back(table_word(ybd_pkg::CMD_SIG_WRITE, 8'h80, 32'hffff_ffff));
      pending_words.push_back(table_word(ybd_pkg::CMD_SIG_WRITE, 8'h7f, 32'h0));
      pending_words.push_back(table_word(ybd_pkg::CMD_SIG_WRITE, 8'h00, 32'h8000));
      pending_words.push_back(table_word(ybd_pkg::CMD_EXP_WRITE, 8'h80, 32'hffff_ffff));
      pending_words.push_back(table_word(ybd_pkg::CMD_EXP_WRITE, 8'h7f, 32'h0));
      pending_words.push_back(table_word(ybd_pkg::CMD_EXP_WRITE, 8'h00, 32'h100));
      begin
         req_word_type w;
         w = table_word(ybd_pkg::CMD_IGNORED, 8'h55, 32'h1234_5678);
         pending_words.push_back(w);
         w = '{command: ybd_pkg::CMD_DECODE, table_index: 0, table_value: 0,
               loc_x: 8'h80, loc_y: 8'h80, loc_w: 8'h80, loc_h: 8'h80,
               prior_x: 8'hff, prior_y: 8'hff, prior_w: 8'hff, prior_h: 8'hff};
         pending_words.push_back(w);
         w.loc_x = 8'h7f; w.loc_y = 8'h7f; w.prior_x = 0; w.prior_y = 0;
         pending_words.push_back(w);
         w.loc_w = 8'h7f; w.loc_h = 8'h7f; w.prior_w = 0; w.prior_h = 0;
         pending_words.push_back(w);
         w.loc_x = 0; w.loc_y = 8'h80; w.loc_w = 0; w.loc_h = 8'h80;
         w.prior_x = 8'h80; w.prior_y = 8'h01; w.prior_w = 8'h80; w.prior_h = 8'h01;
         pending_words.push_back(w);
      end
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         write_csr(ybd_pkg::CSR_GRID_HEIGHT, {8'd0, grids[ph]});
         write_csr(ybd_pkg::CSR_GRID_WIDTH, {8'd0, grids[4 - ph]});
         write_csr(ybd_pkg::CSR_PRIOR_SCALE, scales[ph]);
         case (ph)
            1: begin send_idle_pct = 86; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 86; end
            3: begin send_idle_pct = 10; recv_stall_pct = 10; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         for (int i = 0; i < 200; i++) begin
            pending_words.push_back(random_word());
            if (ph == 4 && i == 100) begin
               while (pending_words.size() != 0 || req_ch.valid || expected_boxes.size() != 0)
                  @(posedge clock);
            end
         end
         drain();
      end

      if (mismatches == 0 && expected_boxes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

FILE: files.f
hw/rtl/ybd_pkg.sv
hw/rtl/ybd_if.sv
hw/rtl/ybd_front.sv
hw/rtl/ybd_fifo.sv
hw/rtl/ybd_div_pipe.sv
hw/rtl/ybd_back.sv
hw/rtl/yolo_box_decode_unit.sv
hw/rtl/ybd_checker.sv
bench/tb.sv
